// ===== hw/rtl/lsr_pkg.sv =====
// Shared types and constants for the L-system symbol rewriter.
package lsr_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned TEXT_W     = 64;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned SYM_LSB    = 0;
  localparam int unsigned LEN_LSB    = SYM_LSB + SYM_W;
  localparam int unsigned TEXT_LSB   = LEN_LSB + LEN_W;

  localparam logic [MODE_W-1:0] MODE_EXPAND   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT,
    ST_RESP
  } lsr_state_e;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             status;
  } lsr_result_t;

endpackage

// ===== hw/rtl/lsystem_symbol_rewriter.sv =====
// Top level of the L-system symbol rewriter: rule tables and lookup sequencer.
//
// One pass of D0L rewriting against a table of up to MAX_RULES rules held in
// two RAMs (keys, and length plus text). One item is in flight at a time. An
// expand or rule write is accepted, then scans the key RAM one entry per cycle
// over up to rule_count entries, then emits the rule's characters, or an
// acknowledgement or a pass-through symbol. A clear goes from acceptance
// straight to its acknowledgement. The key RAM read port, read once per cycle,
// sets the search length. Results sit in an output register, so a waiting
// result does not stall the lookup that follows. No clearing pass runs after
// reset.
module lsystem_symbol_rewriter #(
  parameter int unsigned MAX_RULES   = 16,
  parameter int unsigned MAX_SUB_LEN = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] symbol, [11:8] sub_length, [75:12] sub_text, [79:76] zero
  input  logic [lsr_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [lsr_pkg::MODE_W-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_symbol
  output logic [7:0]                    m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // [0] status
  output logic [0:0]                    m_axis_tuser_o
);
  import lsr_pkg::*;

  localparam int unsigned IW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CW  = $clog2(MAX_RULES + 1);
  localparam int unsigned TW  = 8 * MAX_SUB_LEN;
  localparam int unsigned DW  = LEN_W + TW;
  localparam int unsigned EIW = (MAX_SUB_LEN > 1) ? $clog2(MAX_SUB_LEN) : 1;

  lsr_state_e state_q, state_d;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [TW-1:0]     text_q, text_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  logic [EIW-1:0]    emit_q, emit_d;
  logic [SYM_W-1:0]  resp_sym_q, resp_sym_d;
  logic              resp_status_q, resp_status_d;

  logic [SYM_W-1:0]  in_sym;
  logic [LEN_W-1:0]  in_len, in_len_sat;
  logic              s_fire;

  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic              key_we, data_we;
  logic [IW-1:0]     ram_waddr;
  logic [SYM_W-1:0]  key_rdata;
  logic [DW-1:0]     data_rdata;
  logic [LEN_W-1:0]  rd_len;

  logic              hit, at_end, full, emit_last;
  logic              push, out_ready;
  lsr_result_t       res;

  assign in_sym     = s_axis_tdata_i[SYM_LSB +: SYM_W];
  assign in_len     = s_axis_tdata_i[LEN_LSB +: LEN_W];
  assign in_len_sat = (in_len > LEN_W'(MAX_SUB_LEN)) ? LEN_W'(MAX_SUB_LEN) : in_len;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire     = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_len    = data_rdata[DW-1 -: LEN_W];
  assign hit       = (count_q != '0) && (key_rdata == sym_q);
  assign at_end    = (count_q == '0) || ((CW'(idx_q) + CW'(1)) == count_q);
  assign full      = (count_q == CW'(MAX_RULES));
  assign emit_last = ((LEN_W'(emit_q) + LEN_W'(1)) == len_q);

  lsr_ram #(.WIDTH(SYM_W), .DEPTH(MAX_RULES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (ram_waddr),
    .wdata_i (sym_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (key_rdata)
  );

  lsr_ram #(.WIDTH(DW), .DEPTH(MAX_RULES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (ram_waddr),
    .wdata_i ({len_q, text_q}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (data_rdata)
  );

  lsr_out_reg u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .res_i           (res),
    .ready_o         (out_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == MODE_EXPAND || s_axis_tuser_i == MODE_WRITE) begin
            state_d = ST_SEARCH;
          end else if (s_axis_tuser_i == MODE_CLEAR) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SEARCH: begin
        if (hit && mode_q == MODE_EXPAND) begin
          state_d = (rd_len != '0) ? ST_EMIT : ST_IDLE;
        end else if (hit || at_end) begin
          state_d = ST_RESP;
        end
      end
      ST_EMIT: begin
        if (out_ready && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_d        = mode_q;
    sym_d         = sym_q;
    len_d         = len_q;
    text_d        = text_q;
    idx_d         = idx_q;
    count_d       = count_q;
    emit_d        = emit_q;
    resp_sym_d    = resp_sym_q;
    resp_status_d = resp_status_q;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    key_we        = 1'b0;
    data_we       = 1'b0;
    ram_waddr     = idx_q;
    push          = 1'b0;
    res           = '{sym: '0, last: 1'b1, status: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          mode_d        = s_axis_tuser_i;
          sym_d         = in_sym;
          len_d         = in_len_sat;
          text_d        = s_axis_tdata_i[TEXT_LSB +: TW];
          idx_d         = '0;
          ram_re        = 1'b1;
          resp_sym_d    = '0;
          resp_status_d = 1'b0;
          if (s_axis_tuser_i == MODE_CLEAR) begin
            count_d = '0;
          end
        end
      end
      ST_SEARCH: begin
        ram_re    = 1'b1;
        ram_raddr = IW'(CW'(idx_q) + CW'(1));
        if (hit) begin
          if (mode_q == MODE_EXPAND) begin
            len_d  = rd_len;
            text_d = data_rdata[TW-1:0];
            emit_d = '0;
          end else begin
            data_we = 1'b1;
          end
        end else if (at_end) begin
          if (mode_q == MODE_EXPAND) begin
            resp_sym_d = sym_q;
          end else if (full) begin
            resp_status_d = 1'b1;
          end else begin
            ram_waddr = count_q[IW-1:0];
            key_we    = 1'b1;
            data_we   = 1'b1;
            count_d   = count_q + CW'(1);
          end
        end else begin
          idx_d = IW'(CW'(idx_q) + CW'(1));
        end
      end
      ST_EMIT: begin
        push     = out_ready;
        res.sym  = text_q[8*emit_q +: 8];
        res.last = emit_last;
        if (out_ready) begin
          emit_d = emit_q + EIW'(1);
        end
      end
      ST_RESP: begin
        push       = out_ready;
        res.sym    = resp_sym_q;
        res.status = resp_status_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    sym_q         <= sym_d;
    len_q         <= len_d;
    text_q        <= text_d;
    idx_q         <= idx_d;
    emit_q        <= emit_d;
    resp_sym_q    <= resp_sym_d;
    resp_status_q <= resp_status_d;
  end

endmodule

// ===== hw/rtl/lsr_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lsr_out_reg.sv =====
// Output register stage for result transactions.
module lsr_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsr_pkg::lsr_result_t res_i,
  output logic                ready_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic [0:0]          m_axis_tuser_o
);
  import lsr_pkg::*;

  logic        valid_q, valid_d;
  lsr_result_t res_q, res_d;

  assign ready_o = !valid_q || m_axis_tready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (ready_o) begin
      valid_d = push_i;
      if (push_i) begin
        res_d = res_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = res_q.sym;
  assign m_axis_tlast_o  = res_q.last;
  assign m_axis_tuser_o  = res_q.status;

endmodule

// ===== hw/rtl/lsr_checker.sv =====
// Port-level assertions for the L-system symbol rewriter, bound to the top level.
module lsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [lsr_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input logic [lsr_pkg::MODE_W-1:0]     s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [7:0]                    m_axis_tdata_o,
  input logic                          m_axis_tlast_o,
  input logic [0:0]                    m_axis_tuser_o
);
  import lsr_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transaction dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  a_full_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("table-full status on a non-acknowledgement result");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != MODE_RESERVED)
      |=> !s_axis_tready_o)
    else $error("new item taken while previous one still in progress");

endmodule

bind lsystem_symbol_rewriter lsr_checker u_lsr_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for lsystem_symbol_rewriter: rule table, expansion and stream handshakes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsr_pkg::*;

  localparam int unsigned NUM_RULES = 16;
  localparam int unsigned SUB_MAX   = 8;
  localparam int unsigned ITEMS     = 210;
  localparam int unsigned WD_LIMIT  = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [MODE_W-1:0]     s_axis_tuser_i = MODE_EXPAND;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [7:0]            m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic [0:0]            m_axis_tuser_o;

  lsystem_symbol_rewriter #(
    .MAX_RULES  (NUM_RULES),
    .MAX_SUB_LEN(SUB_MAX)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // rule table mirror
  logic [SYM_W-1:0]  tbl_key  [NUM_RULES];
  logic [LEN_W-1:0]  tbl_len  [NUM_RULES];
  logic [TEXT_W-1:0] tbl_text [NUM_RULES];
  int unsigned       tbl_count;

  lsr_result_t exp_q[$];
  lsr_result_t want;

  bit          no_idle;
  int unsigned errors, items_sent, n_results, wd_count;
  int unsigned n_hit, n_pass, n_empty, n_write, n_drop, n_clear, n_ignored;

  task automatic rewrite_model(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                               input logic [LEN_W-1:0] len, input logic [TEXT_W-1:0] text);
    int          hit;
    lsr_result_t r;
    logic [LEN_W-1:0] sat;
    hit = -1;
    sat = (len > SUB_MAX) ? LEN_W'(SUB_MAX) : len;
    for (int i = 0; i < int'(tbl_count); i++)
      if (hit < 0 && tbl_key[i] == sym) hit = i;
    r.status = 1'b0;
    case (mode)
      MODE_EXPAND: begin
        if (hit < 0) begin
          r.sym  = sym;
          r.last = 1'b1;
          exp_q  = {exp_q, r};
          n_pass++;
        end else if (tbl_len[hit] == 0) begin
          n_empty++;
        end else begin
          for (int i = 0; i < int'(tbl_len[hit]); i++) begin
            r.sym  = tbl_text[hit][8*i +: 8];
            r.last = (i + 1 == int'(tbl_len[hit]));
            exp_q  = {exp_q, r};
          end
          n_hit++;
        end
      end
      MODE_WRITE: begin
        if (hit >= 0) begin
          tbl_len[hit]  = sat;
          tbl_text[hit] = text;
        end else if (tbl_count < NUM_RULES) begin
          tbl_key[tbl_count]  = sym;
          tbl_len[tbl_count]  = sat;
          tbl_text[tbl_count] = text;
          tbl_count++;
        end else begin
          r.status = 1'b1;
          n_drop++;
        end
        r.sym  = '0;
        r.last = 1'b1;
        exp_q  = {exp_q, r};
        n_write++;
      end
      MODE_CLEAR: begin
        tbl_count = 0;
        r.sym     = '0;
        r.last    = 1'b1;
        exp_q     = {exp_q, r};
        n_clear++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [TEXT_W-1:0] text);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = {4'b0, text, len, sym};
    s_axis_tuser_i  = mode;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    rewrite_model(mode, sym, len, text);
    if (mode != MODE_RESERVED) items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [TEXT_W-1:0] rand_text();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    return ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                       : LEN_W'($urandom_range(0, SUB_MAX));
  endfunction

  task automatic test_passthrough();
    send_item(MODE_EXPAND, 8'h00, 4'd0, '0);
    send_item(MODE_EXPAND, 8'hFF, 4'hF, '1);
  endtask

  // full length, saturated length, empty rule, junk above the length
  task automatic test_rule_expansion();
    send_item(MODE_WRITE, 8'h41, 4'd8, 64'h4847_4645_4443_4241);
    send_item(MODE_WRITE, 8'hFF, 4'hF, '1);
    send_item(MODE_WRITE, 8'h00, 4'd0, '0);
    send_item(MODE_WRITE, 8'h42, 4'd1, 64'hFFFF_FFFF_FFFF_FF5A);
    send_item(MODE_EXPAND, 8'hFF, 4'd0, '0);
    send_item(MODE_EXPAND, 8'h00, 4'd0, '0);
    send_item(MODE_EXPAND, 8'h42, 4'd0, '0);
    send_item(MODE_EXPAND, 8'h41, 4'd0, '0);
  endtask

  task automatic test_rule_update();
    send_item(MODE_WRITE, 8'h41, 4'd3, 64'h0000_0000_0063_6261);
    send_item(MODE_EXPAND, 8'h41, 4'd0, '0);
  endtask

  task automatic test_reserved_mode();
    send_item(MODE_RESERVED, 8'hFF, 4'hF, '1);
    send_item(MODE_EXPAND, 8'hFF, 4'd0, '0);
  endtask

  task automatic test_clear();
    send_item(MODE_CLEAR, 8'h41, 4'd2, rand_text());
    send_item(MODE_EXPAND, 8'h41, 4'd0, '0);
    send_item(MODE_EXPAND, 8'h00, 4'd0, '0);
  endtask

  task automatic test_table_full();
    logic [SYM_W-1:0] base, step;
    base = SYM_W'($urandom);
    step = SYM_W'($urandom) | 8'h01;
    send_item(MODE_CLEAR, '0, '0, '0);
    for (int i = 0; i < NUM_RULES; i++)
      send_item(MODE_WRITE, base + SYM_W'(i) * step, rand_len(), rand_text());
    send_item(MODE_WRITE, base + 8'd16 * step, 4'd4, rand_text());
    send_item(MODE_WRITE, base, 4'd8, rand_text());
    send_item(MODE_EXPAND, base + 8'd16 * step, '0, '0);
    send_item(MODE_EXPAND, base + 8'd15 * step, '0, '0);
    send_item(MODE_EXPAND, base, '0, '0);
  endtask

  task automatic random_item(input logic [SYM_W-1:0] sym);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      send_item(MODE_EXPAND, sym, LEN_W'($urandom), rand_text());
    else if (pick < 93) send_item(MODE_WRITE, sym, rand_len(), rand_text());
    else if (pick < 96) send_item(MODE_CLEAR, sym, LEN_W'($urandom), rand_text());
    else                send_item(MODE_RESERVED, sym, LEN_W'($urandom), rand_text());
  endtask

  // pooled symbols so lookups hit and the table fills; a few fully random symbols
  task automatic test_random_traffic(input int unsigned target);
    logic [SYM_W-1:0] pool [24];
    int unsigned      pool_n;
    while (items_sent < target) begin
      pool_n = $urandom_range(4, 24);
      foreach (pool[i]) pool[i] = SYM_W'($urandom);
      if ($urandom_range(0, 2) == 0) send_item(MODE_CLEAR, '0, '0, '0);
      repeat ($urandom_range(10, 40)) begin
        if (items_sent < target) begin
          if ($urandom_range(0, 19) == 0) random_item(SYM_W'($urandom));
          else random_item(pool[$urandom_range(0, pool_n - 1)]);
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    logic [SYM_W-1:0] pool [8];
    foreach (pool[i]) pool[i] = SYM_W'($urandom);
    no_idle = 1'b1;
    repeat (30) random_item(pool[$urandom_range(0, 7)]);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (6) random_item(SYM_W'($urandom_range(0, 3)));
    drain_results();
    repeat (4) random_item(SYM_W'($urandom_range(0, 3)));
  endtask

  // result side: random stall per transaction
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_results++;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual sym=%h last=%b status=%b",
                 $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        errors++;
      end else begin
        want = exp_q.pop_front();
        if (m_axis_tdata_o !== want.sym) begin
          $display("%0t: out_symbol mismatch: expected %h actual %h",
                   $time, want.sym, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: last mismatch: expected %b actual %b",
                   $time, want.last, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tuser_o[0] !== want.status) begin
          $display("%0t: status mismatch: expected %b actual %b",
                   $time, want.status, m_axis_tuser_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        wd_count <= 0;
      end else if (wd_count >= WD_LIMIT) begin
        $display("%0t: timeout, %0d results still outstanding", $time, exp_q.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        wd_count <= wd_count + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_passthrough();
    test_rule_expansion();
    test_rule_update();
    test_reserved_mode();
    test_clear();
    test_table_full();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic(ITEMS);
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d expansions (%0d hit, %0d pass-through, %0d empty), %0d rule writes",
             n_hit + n_pass + n_empty, n_hit, n_pass, n_empty, n_write);
    $display("  %0d writes dropped on full table, %0d clears, %0d ignored, %0d results checked",
             n_drop, n_clear, n_ignored, n_results);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lsr_pkg.sv
hw/rtl/lsr_ram.sv
hw/rtl/lsr_out_reg.sv
hw/rtl/lsystem_symbol_rewriter.sv
hw/rtl/lsr_checker.sv
bench/tb.sv
